// ===== sv/ggc_pkg.sv =====
// Shared types and constants for the greedy graph coloring block.
// Standalone package; no dependencies.
package ggc_pkg;

    // Storage slots and the vertex limit of a run
    localparam int SLOTS        = 32;
    localparam int MAX_VERTICES = 32;
    localparam int VTX_W        = 5;
    localparam int ROW_W        = 32;
    localparam int CNT_W        = 6;

    // Register reset value
    localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 6'd31;

    // Input item modes
    localparam logic [1:0] MODE_ADJ = 2'd0;
    localparam logic [1:0] MODE_ORD = 2'd1;
    localparam logic [1:0] MODE_RUN = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [VTX_W-1:0] index;
        logic [ROW_W-1:0] row_bits;
        logic [VTX_W-1:0] order_vertex;
    } in_word_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic [VTX_W-1:0] color;
        logic             last;
    } out_word_t;

endpackage

// ===== sv/greedy_graph_coloring.sv =====
// Greedy first-fit graph coloring: adjacency/order memories and a microcoded sequencer.
// Load words are accepted while idle. A run word colors each order position in turn: the
// color memory is scanned one vertex per cycle, then a free color is painted; afterwards each
// result is read back and presented, stalling while the output is held.
// Reset clears the sequencer, output valid and vertex_count (to 31); memories are not cleared.
// Depends on ggc_pkg.
module greedy_graph_coloring (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  ggc_pkg::in_word_t        s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output ggc_pkg::out_word_t       m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [ggc_pkg::CNT_W-1:0] cfg_data
);
    import ggc_pkg::*;

    // Sequencer step codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ORD   = 4'd1;
    localparam logic [3:0] S_ADJ   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_TAIL  = 4'd4;
    localparam logic [3:0] S_PAINT = 4'd5;
    localparam logic [3:0] S_OORD  = 4'd6;
    localparam logic [3:0] S_OCOL  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    // Stall selects
    localparam logic [1:0] W_NONE = 2'd0;
    localparam logic [1:0] W_IN   = 2'd1;
    localparam logic [1:0] W_SCAN = 2'd2;
    localparam logic [1:0] W_OUT  = 2'd3;

    // Jump selects
    localparam logic [1:0] J_NEVER  = 2'd0;
    localparam logic [1:0] J_ALWAYS = 2'd1;
    localparam logic [1:0] J_MORE   = 2'd2;

    localparam int CAP = (MAX_VERTICES < SLOTS) ? MAX_VERTICES : SLOTS;
    localparam logic [CNT_W-1:0] CAP_W = CNT_W'(CAP);

    typedef struct packed {
        logic       ready;
        logic       ord_rd;
        logic       adj_rd;
        logic       scan;
        logic       paint;
        logic       col_rd;
        logic       emit;
        logic [1:0] stall_sel;
        logic [1:0] jmp_sel;
        logic [3:0] target;
    } ctrl_t;

    // Control store: one word per step
    function automatic ctrl_t prog(input logic [3:0] step);
        ctrl_t w;
        w = '0;
        unique case (step)
            S_IDLE:  begin w.ready = 1'b1; w.stall_sel = W_IN; end
            S_ORD:   begin w.ord_rd = 1'b1; end
            S_ADJ:   begin w.adj_rd = 1'b1; end
            S_SCAN:  begin w.scan = 1'b1; w.stall_sel = W_SCAN; end
            S_TAIL:  begin end
            S_PAINT: begin w.paint = 1'b1; w.jmp_sel = J_MORE; w.target = S_ORD; end
            S_OORD:  begin w.ord_rd = 1'b1; end
            S_OCOL:  begin w.col_rd = 1'b1; end
            S_EMIT:  begin
                w.emit = 1'b1; w.stall_sel = W_OUT; w.jmp_sel = J_MORE; w.target = S_OORD;
            end
            S_DONE:  begin w.jmp_sel = J_ALWAYS; w.target = S_IDLE; end
            default: begin w.jmp_sel = J_ALWAYS; w.target = S_IDLE; end
        endcase
        return w;
    endfunction

    // Memories
    logic [ROW_W-1:0] adj_mem [SLOTS];
    logic [VTX_W-1:0] ord_mem [SLOTS];
    logic [VTX_W-1:0] col_mem [SLOTS];

    logic [3:0]       pc_reg, pc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [VTX_W-1:0] i_reg, i_next;
    logic [VTX_W-1:0] j_reg, j_next;
    logic [ROW_W-1:0] mask_reg, mask_next;
    logic [ROW_W-1:0] used_reg, used_next;
    logic             nb_reg, nb_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        m_data_reg, m_data_next;
    logic [VTX_W-1:0] ord_q;
    logic [ROW_W-1:0] row_q;
    logic [VTX_W-1:0] col_q;

    ctrl_t            cw;
    logic             in_acc;
    logic             run_go;
    logic [VTX_W-1:0] n_last;
    logic             pos_last;
    logic             out_free;
    logic             stall;
    logic             jump;
    logic [VTX_W-1:0] col_addr;
    logic [VTX_W-1:0] free_color;

    assign cw        = prog(pc_reg);
    assign s_ready   = cw.ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign in_acc    = s_valid && s_ready;
    assign run_go    = in_acc && (s_data.mode == MODE_RUN);
    assign out_free  = !m_valid_reg || m_ready;
    assign pos_last  = (i_reg == n_last);

    // Clamp the vertex count to 1..CAP, kept as its last index
    always_comb begin
        if (count_reg == '0) begin
            n_last = '0;
        end else if (count_reg >= CAP_W) begin
            n_last = VTX_W'(CAP - 1);
        end else begin
            n_last = VTX_W'(count_reg - 1'b1);
        end
    end

    // Lowest color absent from the used set
    always_comb begin
        free_color = '0;
        for (int c = ROW_W - 1; c >= 0; c--) begin
            if (!used_reg[c]) begin
                free_color = VTX_W'(c);
            end
        end
    end

    // Step sequencing
    always_comb begin
        unique case (cw.stall_sel)
            W_NONE:  stall = 1'b0;
            W_IN:    stall = !run_go;
            W_SCAN:  stall = (j_reg != n_last);
            W_OUT:   stall = !out_free;
            default: stall = 1'b0;
        endcase
        unique case (cw.jmp_sel)
            J_NEVER:  jump = 1'b0;
            J_ALWAYS: jump = 1'b1;
            J_MORE:   jump = !pos_last;
            default:  jump = 1'b0;
        endcase
        if (stall) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = cw.target;
        end else begin
            pc_next = pc_reg + 4'd1;
        end
    end

    // Datapath control
    always_comb begin
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        mask_next    = mask_reg;
        used_next    = nb_reg ? (used_reg | (ROW_W'(1) << col_q)) : used_reg;
        nb_next      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (cfg_valid && cfg_ready) begin
            count_next = cfg_data;
        end
        // start a run: clear colored set, rewind position
        if (cw.ready && run_go) begin
            mask_next = '0;
            i_next    = '0;
        end
        if (cw.adj_rd) begin
            j_next    = '0;
            used_next = '0;
        end
        // step through vertices, flag colored neighbors
        if (cw.scan) begin
            nb_next = row_q[j_reg] && mask_reg[j_reg];
            if (j_reg != n_last) begin
                j_next = j_reg + 1'b1;
            end
        end
        if (cw.paint) begin
            mask_next = mask_reg | (ROW_W'(1) << ord_q);
            i_next    = pos_last ? '0 : i_reg + 1'b1;
        end
        // present one result when the output register frees up
        if (cw.emit && out_free) begin
            m_valid_next       = 1'b1;
            m_data_next.vertex = ord_q;
            m_data_next.color  = col_q;
            m_data_next.last   = pos_last;
            i_next             = pos_last ? '0 : i_reg + 1'b1;
        end
    end

    assign col_addr = cw.scan ? j_reg : ord_q;

    // Memory ports: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (in_acc && (s_data.mode == MODE_ADJ)) begin
            adj_mem[s_data.index] <= s_data.row_bits;
        end
        if (cw.adj_rd) begin
            row_q <= adj_mem[ord_q];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && (s_data.mode == MODE_ORD)) begin
            ord_mem[s_data.index] <= s_data.order_vertex;
        end
        if (cw.ord_rd) begin
            ord_q <= ord_mem[i_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.paint) begin
            col_mem[ord_q] <= free_color;
        end
        if (cw.scan || cw.col_rd) begin
            col_q <= col_mem[col_addr];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= S_IDLE;
            count_reg   <= VERTEX_COUNT_RST;
            nb_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            count_reg   <= count_next;
            nb_reg      <= nb_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        mask_reg   <= mask_next;
        used_reg   <= used_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_run_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        run_go |=> (pc_reg == S_ORD))
        else $error("run word did not start the sequence");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == S_SCAN) |-> (j_reg <= n_last))
        else $error("neighbor scan ran past the vertex count");

    a_scan_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == S_PAINT) |-> !nb_reg)
        else $error("color chosen before the scan drained");

    a_paint_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == S_PAINT) |=> mask_reg[$past(ord_q)])
        else $error("painted vertex not marked colored");

    a_emit_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && (pc_reg != S_EMIT)) |=> !m_valid_reg)
        else $error("result presented outside the emit step");
`endif

endmodule
